// ===== hw/rtl/mcfbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfbs_pkg: shared types and constants of the frame bucket synchronizer
// Field widths, register indexes, controller states, and the command and
// status records that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mcfbs_pkg;

    // Fixed field widths.
    localparam int STAMP_W    = 63;
    localparam int GRID_W     = 30;
    localparam int CAMS_W     = 2;
    localparam int CAM_W      = 2;
    localparam int STREAM_W   = 2;
    localparam int STREAMS    = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 30;

    // Register reset values.
    localparam logic [GRID_W-1:0] GRID_RESET = 30'd33330000;
    localparam logic [CAMS_W-1:0] CAMS_RESET = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMS = 4'd1;

    // Stream codes.
    localparam logic [STREAM_W-1:0] STREAM_RGB   = 2'd0;
    localparam logic [STREAM_W-1:0] STREAM_DEPTH = 2'd1;
    localparam logic [STREAM_W-1:0] STREAM_CONF  = 2'd2;
    localparam logic [STREAM_W-1:0] STREAM_EXTRA = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_STAMP,
        S_WAIT_STAMP,
        S_PLACE,
        S_FIND_FIRST,
        S_SET_A,
        S_CHECK,
        S_FIND_NEXT,
        S_TRY_B,
        S_MADDR,
        S_MCMP,
        S_JUDGE,
        S_DIV_MASTER,
        S_WAIT_MASTER,
        S_TREAD,
        S_EMIT,
        S_FREE,
        S_EVICT_CHECK,
        S_EVICT_FIND,
        S_EVICT_KILL
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_STAMP,
        OP_PLACE,
        OP_FIND_FIRST,
        OP_SET_A,
        OP_PICK_A,
        OP_FIND_NEXT,
        OP_TRYB,
        OP_MADDR,
        OP_MCMP,
        OP_JUDGE,
        OP_DIV_MASTER,
        OP_TREAD,
        OP_EMIT,
        OP_FREE,
        OP_KILL
    } t_op;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic in_frame;
        logic div_done;
        logic slot_avail;
        logic sweep_last;
        logic best_found;
        logic all_a;
        logic fill_ok;
        logic cam_last;
        logic reject;
        logic tread_last;
        logic out_free;
        logic all_valid;
    } t_status;

endpackage

// ===== hw/rtl/mcfbs_in_if.sv =====
// ----------------------------------------------------------------------------
// mcfbs_in_if: frame and calibration arrival channel
// Valid/ready channel carrying one arrival item.
// ----------------------------------------------------------------------------
interface mcfbs_in_if #(
    parameter int TAG_WIDTH = 16
) ();
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [mcfbs_pkg::CAM_W-1:0]      camera;
    logic [mcfbs_pkg::STREAM_W-1:0]   stream;
    logic [mcfbs_pkg::STAMP_W-1:0]    stamp_ns;
    logic [TAG_WIDTH-1:0]             frame_tag;

    modport source (output valid, kind, camera, stream, stamp_ns, frame_tag, input ready);
    modport sink   (input valid, kind, camera, stream, stamp_ns, frame_tag, output ready);
endinterface

// ===== hw/rtl/mcfbs_out_if.sv =====
// ----------------------------------------------------------------------------
// mcfbs_out_if: snapshot entry channel
// Valid/ready channel carrying one camera entry of a snapshot.
// ----------------------------------------------------------------------------
interface mcfbs_out_if #(
    parameter int TAG_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic [mcfbs_pkg::CAM_W-1:0]   out_camera;
    logic [TAG_WIDTH-1:0]          rgb_tag;
    logic [TAG_WIDTH-1:0]          depth_tag;
    logic [TAG_WIDTH-1:0]          conf_tag;
    logic [mcfbs_pkg::STAMP_W-1:0] snapshot_stamp_ns;
    logic                          last_entry;

    modport source (output valid, out_camera, rgb_tag, depth_tag, conf_tag,
                    snapshot_stamp_ns, last_entry, input ready);
    modport sink   (input valid, out_camera, rgb_tag, depth_tag, conf_tag,
                    snapshot_stamp_ns, last_entry, output ready);
endinterface

// ===== hw/rtl/mcfbs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mcfbs_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mcfbs_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [mcfbs_pkg::CFG_IDX_W-1:0]  index;
    logic [mcfbs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mcfbs_ram.sv =====
// ----------------------------------------------------------------------------
// mcfbs_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcfbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/mcfbs_div.sv =====
// ----------------------------------------------------------------------------
// mcfbs_div: rounding stamp-to-bucket divider
// Restoring division of a stamp by the grid, one quotient bit per cycle,
// followed by a round-half-up correction step.
// ----------------------------------------------------------------------------
module mcfbs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mcfbs_pkg::STAMP_W-1:0] i_dividend,
    input  logic [mcfbs_pkg::GRID_W-1:0]  i_grid,
    output logic                          o_done,
    output logic [mcfbs_pkg::STAMP_W-1:0] o_quot
);
    localparam int SW   = mcfbs_pkg::STAMP_W;
    localparam int GW   = mcfbs_pkg::GRID_W;
    localparam int CW   = $clog2(SW);

    logic          r_busy;
    logic          r_fix;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_dvd;
    logic [SW-1:0] r_q;
    logic [GW-1:0] r_rem;
    logic [GW-1:0] r_g;

    logic [GW:0] w_trial;
    logic [GW:0] w_diff;
    logic        w_ge;
    logic        w_round;

    // One restoring step and the rounding test.
    always_comb begin
        w_trial = {r_rem, r_dvd[SW-1]};
        w_ge    = (w_trial >= {1'b0, r_g});
        w_diff  = w_trial - {1'b0, r_g};
        w_round = ({r_rem, 1'b0} >= {1'b0, r_g});
    end

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fix  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath of the divider; a zero grid acts as one.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_g   <= (i_grid == '0) ? GW'(1) : i_grid;
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[GW-1:0] : w_trial[GW-1:0];
            r_q   <= {r_q[SW-2:0], w_ge};
            r_dvd <= {r_dvd[SW-2:0], 1'b0};
        end else if (r_fix) begin
            r_q <= r_q + SW'(w_round);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== hw/rtl/mcfbs_dp.sv =====
// ----------------------------------------------------------------------------
// mcfbs_dp: bucket store and snapshot datapath
// Holds registers, slot table, present bits, tag and stamp memories, the
// divider and the output register, and acts on controller commands.
// ----------------------------------------------------------------------------
module mcfbs_dp #(
    parameter int NUM_CAMERAS = 3,
    parameter int MAX_BUCKETS = 8,
    parameter int TAG_WIDTH   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mcfbs_in_if.sink             i_in,
    mcfbs_out_if.source          o_out,
    mcfbs_cfg_if.sink            i_cfg,
    input  mcfbs_pkg::t_cmd      i_cmd,
    output mcfbs_pkg::t_status   o_status
);
    localparam int SW        = mcfbs_pkg::STAMP_W;
    localparam int STREAMS   = mcfbs_pkg::STREAMS;
    localparam int SLOTS     = MAX_BUCKETS + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CAMI_W    = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int N_W       = $clog2(NUM_CAMERAS + 1);
    localparam int TAG_DEPTH = SLOTS * NUM_CAMERAS * STREAMS;
    localparam int TAG_AW    = $clog2(TAG_DEPTH);
    localparam int RGB_DEPTH = SLOTS * NUM_CAMERAS;
    localparam int RGB_AW    = $clog2(RGB_DEPTH);

    function automatic logic [TAG_AW-1:0] tag_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [CAMI_W-1:0] c,
                                                   input logic [1:0]        k);
        return TAG_AW'((int'(s) * NUM_CAMERAS + int'(c)) * STREAMS + int'(k));
    endfunction

    function automatic logic [RGB_AW-1:0] rgb_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [CAMI_W-1:0] c);
        return RGB_AW'(int'(s) * NUM_CAMERAS + int'(c));
    endfunction

    // Registers and store.
    logic [mcfbs_pkg::GRID_W-1:0] r_grid;
    logic [mcfbs_pkg::CAMS_W-1:0] r_cams;
    logic [NUM_CAMERAS-1:0]       r_calib;
    logic                         r_first_done;
    logic [SW-1:0]                r_last;
    logic [mcfbs_pkg::CAM_W-1:0]  r_cam;
    logic [1:0]                   r_st;
    logic [SW-1:0]                r_stamp;
    logic [TAG_WIDTH-1:0]         r_tag;
    logic [SLOTS-1:0]             r_valid;
    logic [SW-1:0]                r_id [SLOTS];
    logic [STREAMS-1:0]           r_present [SLOTS][NUM_CAMERAS];
    logic [SLOT_W-1:0]            r_cnt;
    logic                         r_best_found;
    logic [SLOT_W-1:0]            r_best_slot;
    logic [SW-1:0]                r_best_id;
    logic [SLOT_W-1:0]            r_a;
    logic [SW-1:0]                r_a_id;
    logic [SLOT_W-1:0]            r_pick [NUM_CAMERAS];
    logic [CAMI_W-1:0]            r_cami;
    logic [SW-1:0]                r_master;
    logic [1:0]                   r_sub;
    logic [TAG_WIDTH-1:0]         r_tags [STREAMS];
    logic                         r_out_valid;
    logic [mcfbs_pkg::CAM_W-1:0]  r_out_cam;
    logic [TAG_WIDTH-1:0]         r_out_rgb;
    logic [TAG_WIDTH-1:0]         r_out_depth;
    logic [TAG_WIDTH-1:0]         r_out_conf;
    logic [SW-1:0]                r_out_stamp;
    logic                         r_out_last;

    // Combinational signals.
    mcfbs_pkg::t_op         w_op;
    logic                   w_accept;
    logic [N_W-1:0]         w_n;
    logic [NUM_CAMERAS-1:0] w_need;
    logic                   w_in_go;
    logic                   w_div_done;
    logic [SW-1:0]          w_quot;
    logic [SLOTS-1:0]       w_match;
    logic                   w_any_match;
    logic                   w_any_free;
    logic [SLOT_W-1:0]      w_match_slot;
    logic [SLOT_W-1:0]      w_free_slot;
    logic [SLOT_W-1:0]      w_sel;
    logic                   w_slot_new;
    logic                   w_avail;
    logic [NUM_CAMERAS-1:0] w_ready_a;
    logic [NUM_CAMERAS-1:0] w_ready_b;
    logic                   w_all_a;
    logic                   w_fill_ok;
    logic                   w_sweep;
    logic                   w_sweep_last;
    logic                   w_eff_found;
    logic                   w_cand;
    logic                   w_take;
    logic                   w_cam_last;
    logic                   w_reject;
    logic                   w_out_free;
    logic [SW-1:0]          w_min;
    logic [1:0]             w_sub_k;
    logic                   w_tag_we;
    logic [TAG_AW-1:0]      w_tag_waddr;
    logic [TAG_AW-1:0]      w_tag_raddr;
    logic [TAG_WIDTH-1:0]   w_tag_rdata;
    logic                   w_rgb_we;
    logic [RGB_AW-1:0]      w_rgb_waddr;
    logic [RGB_AW-1:0]      w_rgb_raddr;
    logic [SW-1:0]          w_rgb_rdata;
    logic                   w_div_start;
    logic [SW-1:0]          w_div_in;

    assign w_op     = i_cmd.op;
    assign w_accept = i_in.valid && i_cmd.in_ready;

    // Effective camera count and the gate for frames.
    always_comb begin
        if (r_cams == '0) begin
            w_n = N_W'(1);
        end else if (int'(r_cams) > NUM_CAMERAS) begin
            w_n = N_W'(NUM_CAMERAS);
        end else begin
            w_n = N_W'(r_cams);
        end
        for (int c = 0; c < NUM_CAMERAS; c++) begin
            w_need[c] = (c < int'(w_n));
        end
        w_in_go = !i_in.kind && (int'(i_in.camera) < int'(w_n))
                  && ((r_calib & w_need) == w_need);
        w_cam_last = (int'(r_cami) == int'(w_n) - 1);
    end

    // Slot lookup: the lowest matching slot, else the lowest free slot.
    always_comb begin
        w_match_slot = '0;
        w_free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_id[i] == w_quot);
            if (w_match[i]) begin
                w_match_slot = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                w_free_slot = SLOT_W'(i);
            end
        end
        w_any_match = |w_match;
        w_any_free  = !(&r_valid);
        w_slot_new  = !w_any_match;
        w_sel       = w_any_match ? w_match_slot : w_free_slot;
        w_avail     = w_any_match || w_any_free;
    end

    // Completeness of bucket a and fill from the next bucket.
    always_comb begin
        w_all_a   = 1'b1;
        w_fill_ok = 1'b1;
        for (int c = 0; c < NUM_CAMERAS; c++) begin
            w_ready_a[c] = &r_present[r_a][c];
            w_ready_b[c] = &r_present[r_best_slot][c];
            if (w_need[c] && !w_ready_a[c]) begin
                w_all_a = 1'b0;
            end
            if (w_need[c] && !w_ready_a[c] && !w_ready_b[c]) begin
                w_fill_ok = 1'b0;
            end
        end
    end

    // Sweep over the slot table for ordered search and freeing.
    always_comb begin
        w_sweep      = (w_op == mcfbs_pkg::OP_FIND_FIRST) || (w_op == mcfbs_pkg::OP_FIND_NEXT)
                       || (w_op == mcfbs_pkg::OP_FREE);
        w_sweep_last = (r_cnt == SLOT_W'(SLOTS - 1));
        w_eff_found  = (r_cnt != '0) && r_best_found;
        w_cand       = r_valid[r_cnt]
                       && ((w_op == mcfbs_pkg::OP_FIND_FIRST) || (r_id[r_cnt] > r_a_id));
        w_take       = w_cand && (!w_eff_found || (r_id[r_cnt] < r_best_id));
    end

    // Master stamp, rejection test and output space.
    always_comb begin
        w_min      = ((r_cami == '0) || (w_rgb_rdata < r_master)) ? w_rgb_rdata : r_master;
        w_reject   = r_first_done && (r_master <= r_last);
        w_out_free = !r_out_valid || o_out.ready;
    end

    // Memory ports.
    always_comb begin
        w_sub_k     = (r_sub == 2'd3) ? 2'd2 : r_sub;
        w_tag_we    = (w_op == mcfbs_pkg::OP_PLACE) && w_avail;
        w_tag_waddr = tag_addr(w_sel, CAMI_W'(r_cam), r_st);
        w_tag_raddr = tag_addr(r_pick[r_cami], r_cami, w_sub_k);
        w_rgb_we    = w_tag_we && (r_st == mcfbs_pkg::STREAM_RGB);
        w_rgb_waddr = rgb_addr(w_sel, CAMI_W'(r_cam));
        w_rgb_raddr = rgb_addr(r_pick[r_cami], r_cami);
        w_div_start = (w_op == mcfbs_pkg::OP_DIV_STAMP) || (w_op == mcfbs_pkg::OP_DIV_MASTER);
        w_div_in    = (w_op == mcfbs_pkg::OP_DIV_MASTER) ? r_master : r_stamp;
    end

    mcfbs_ram #(.WIDTH(TAG_WIDTH), .DEPTH(TAG_DEPTH)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_tag_waddr),
        .i_wdata (r_tag),
        .i_raddr (w_tag_raddr),
        .o_rdata (w_tag_rdata)
    );

    mcfbs_ram #(.WIDTH(SW), .DEPTH(RGB_DEPTH)) u_rgb_ram (
        .i_clk   (i_clk),
        .i_we    (w_rgb_we),
        .i_waddr (w_rgb_waddr),
        .i_wdata (r_stamp),
        .i_raddr (w_rgb_raddr),
        .o_rdata (w_rgb_rdata)
    );

    mcfbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .i_grid     (r_grid),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Control state: registers, valid and present bits, counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid       <= mcfbs_pkg::GRID_RESET;
            r_cams       <= mcfbs_pkg::CAMS_RESET;
            r_calib      <= '0;
            r_first_done <= 1'b0;
            r_last       <= '0;
            r_valid      <= '0;
            r_cnt        <= '0;
            r_best_found <= 1'b0;
            r_cami       <= '0;
            r_sub        <= '0;
            r_out_valid  <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                for (int c = 0; c < NUM_CAMERAS; c++) begin
                    r_present[s][c] <= '0;
                end
            end
        end else begin
            // Register writes.
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    mcfbs_pkg::REG_GRID: r_grid <= i_cfg.data[mcfbs_pkg::GRID_W-1:0];
                    mcfbs_pkg::REG_CAMS: r_cams <= i_cfg.data[mcfbs_pkg::CAMS_W-1:0];
                    default: ;
                endcase
            end

            // Calibration arrivals.
            if (w_accept && i_in.kind && (int'(i_in.camera) < NUM_CAMERAS)) begin
                r_calib[CAMI_W'(i_in.camera)] <= 1'b1;
            end

            // Sweep and read counters.
            r_cnt <= (w_sweep && !w_sweep_last) ? r_cnt + 1'b1 : '0;
            r_sub <= (w_op == mcfbs_pkg::OP_TREAD) ? r_sub + 2'd1 : 2'd0;

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_op)
                mcfbs_pkg::OP_PLACE: begin
                    if (w_avail) begin
                        if (w_slot_new) begin
                            r_valid[w_sel] <= 1'b1;
                            for (int c = 0; c < NUM_CAMERAS; c++) begin
                                r_present[w_sel][c] <= '0;
                            end
                        end
                        r_present[w_sel][CAMI_W'(r_cam)][r_st] <= 1'b1;
                    end
                end
                mcfbs_pkg::OP_FIND_FIRST, mcfbs_pkg::OP_FIND_NEXT: begin
                    if (w_take) begin
                        r_best_found <= 1'b1;
                    end else if (r_cnt == '0) begin
                        r_best_found <= 1'b0;
                    end
                end
                mcfbs_pkg::OP_PICK_A, mcfbs_pkg::OP_TRYB, mcfbs_pkg::OP_DIV_MASTER: begin
                    r_cami <= '0;
                end
                mcfbs_pkg::OP_MCMP: begin
                    if (!w_cam_last) begin
                        r_cami <= r_cami + 1'b1;
                    end
                end
                mcfbs_pkg::OP_JUDGE: begin
                    if (!w_reject) begin
                        r_first_done <= 1'b1;
                        r_last       <= r_master;
                    end
                end
                mcfbs_pkg::OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_present[r_pick[r_cami]][r_cami] <= '0;
                    if (!w_cam_last) begin
                        r_cami <= r_cami + 1'b1;
                    end
                end
                mcfbs_pkg::OP_FREE: begin
                    if (r_valid[r_cnt] && (r_id[r_cnt] <= w_quot)) begin
                        r_valid[r_cnt] <= 1'b0;
                    end
                end
                mcfbs_pkg::OP_KILL: begin
                    if (r_best_found) begin
                        r_valid[r_best_slot] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cam   <= i_in.camera;
            r_st    <= (i_in.stream == mcfbs_pkg::STREAM_EXTRA) ? mcfbs_pkg::STREAM_CONF
                                                                : i_in.stream;
            r_stamp <= i_in.stamp_ns;
            r_tag   <= i_in.frame_tag;
        end
        case (w_op)
            mcfbs_pkg::OP_PLACE: begin
                if (w_avail && w_slot_new) begin
                    r_id[w_sel] <= w_quot;
                end
            end
            mcfbs_pkg::OP_FIND_FIRST, mcfbs_pkg::OP_FIND_NEXT: begin
                if (w_take) begin
                    r_best_slot <= r_cnt;
                    r_best_id   <= r_id[r_cnt];
                end
            end
            mcfbs_pkg::OP_SET_A: begin
                r_a    <= r_best_slot;
                r_a_id <= r_best_id;
            end
            mcfbs_pkg::OP_PICK_A: begin
                for (int c = 0; c < NUM_CAMERAS; c++) begin
                    r_pick[c] <= r_a;
                end
            end
            mcfbs_pkg::OP_TRYB: begin
                if (r_best_found) begin
                    if (w_fill_ok) begin
                        for (int c = 0; c < NUM_CAMERAS; c++) begin
                            r_pick[c] <= w_ready_a[c] ? r_a : r_best_slot;
                        end
                    end else begin
                        r_a    <= r_best_slot;
                        r_a_id <= r_best_id;
                    end
                end
            end
            mcfbs_pkg::OP_MCMP: begin
                r_master <= w_min;
            end
            mcfbs_pkg::OP_TREAD: begin
                if (r_sub != 2'd0) begin
                    r_tags[r_sub - 2'd1] <= w_tag_rdata;
                end
            end
            mcfbs_pkg::OP_EMIT: begin
                r_out_cam   <= mcfbs_pkg::CAM_W'(r_cami);
                r_out_rgb   <= r_tags[0];
                r_out_depth <= r_tags[1];
                r_out_conf  <= r_tags[2];
                r_out_stamp <= r_master;
                r_out_last  <= w_cam_last;
            end
            default: ;
        endcase
    end

    // Channel outputs.
    assign i_in.ready              = i_cmd.in_ready;
    assign i_cfg.ready             = 1'b1;
    assign o_out.valid             = r_out_valid;
    assign o_out.out_camera        = r_out_cam;
    assign o_out.rgb_tag           = r_out_rgb;
    assign o_out.depth_tag         = r_out_depth;
    assign o_out.conf_tag          = r_out_conf;
    assign o_out.snapshot_stamp_ns = r_out_stamp;
    assign o_out.last_entry        = r_out_last;

    // Status to the controller.
    always_comb begin
        o_status.in_frame   = i_in.valid && w_in_go;
        o_status.div_done   = w_div_done;
        o_status.slot_avail = w_avail;
        o_status.sweep_last = w_sweep_last;
        o_status.best_found = r_best_found;
        o_status.all_a      = w_all_a;
        o_status.fill_ok    = w_fill_ok;
        o_status.cam_last   = w_cam_last;
        o_status.reject     = w_reject;
        o_status.tread_last = (r_sub == 2'd3);
        o_status.out_free   = w_out_free;
        o_status.all_valid  = &r_valid;
    end
endmodule

// ===== hw/rtl/mcfbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcfbs_ctrl: sequencing state machine of the synchronizer
// Walks each frame through bucketing, ordered scan, master stamp, emission,
// freeing and eviction by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module mcfbs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcfbs_pkg::t_status   i_status,
    output mcfbs_pkg::t_cmd      o_cmd
);
    mcfbs_pkg::t_state r_state;
    mcfbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcfbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcfbs_pkg::S_IDLE:
                if (i_status.in_frame) n_state = mcfbs_pkg::S_DIV_STAMP;
            mcfbs_pkg::S_DIV_STAMP:
                n_state = mcfbs_pkg::S_WAIT_STAMP;
            mcfbs_pkg::S_WAIT_STAMP:
                if (i_status.div_done) n_state = mcfbs_pkg::S_PLACE;
            mcfbs_pkg::S_PLACE:
                n_state = i_status.slot_avail ? mcfbs_pkg::S_FIND_FIRST : mcfbs_pkg::S_IDLE;
            mcfbs_pkg::S_FIND_FIRST:
                if (i_status.sweep_last) n_state = mcfbs_pkg::S_SET_A;
            mcfbs_pkg::S_SET_A:
                n_state = i_status.best_found ? mcfbs_pkg::S_CHECK : mcfbs_pkg::S_EVICT_CHECK;
            mcfbs_pkg::S_CHECK:
                n_state = i_status.all_a ? mcfbs_pkg::S_MADDR : mcfbs_pkg::S_FIND_NEXT;
            mcfbs_pkg::S_FIND_NEXT:
                if (i_status.sweep_last) n_state = mcfbs_pkg::S_TRY_B;
            mcfbs_pkg::S_TRY_B: begin
                if (!i_status.best_found) begin
                    n_state = mcfbs_pkg::S_EVICT_CHECK;
                end else if (i_status.fill_ok) begin
                    n_state = mcfbs_pkg::S_MADDR;
                end else begin
                    n_state = mcfbs_pkg::S_CHECK;
                end
            end
            mcfbs_pkg::S_MADDR:
                n_state = mcfbs_pkg::S_MCMP;
            mcfbs_pkg::S_MCMP:
                n_state = i_status.cam_last ? mcfbs_pkg::S_JUDGE : mcfbs_pkg::S_MADDR;
            mcfbs_pkg::S_JUDGE:
                n_state = i_status.reject ? mcfbs_pkg::S_EVICT_CHECK : mcfbs_pkg::S_DIV_MASTER;
            mcfbs_pkg::S_DIV_MASTER:
                n_state = mcfbs_pkg::S_WAIT_MASTER;
            mcfbs_pkg::S_WAIT_MASTER:
                if (i_status.div_done) n_state = mcfbs_pkg::S_TREAD;
            mcfbs_pkg::S_TREAD:
                if (i_status.tread_last) n_state = mcfbs_pkg::S_EMIT;
            mcfbs_pkg::S_EMIT:
                if (i_status.out_free) begin
                    n_state = i_status.cam_last ? mcfbs_pkg::S_FREE : mcfbs_pkg::S_TREAD;
                end
            mcfbs_pkg::S_FREE:
                if (i_status.sweep_last) n_state = mcfbs_pkg::S_EVICT_CHECK;
            mcfbs_pkg::S_EVICT_CHECK:
                n_state = i_status.all_valid ? mcfbs_pkg::S_EVICT_FIND : mcfbs_pkg::S_IDLE;
            mcfbs_pkg::S_EVICT_FIND:
                if (i_status.sweep_last) n_state = mcfbs_pkg::S_EVICT_KILL;
            mcfbs_pkg::S_EVICT_KILL:
                n_state = mcfbs_pkg::S_IDLE;
            default:
                n_state = mcfbs_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = mcfbs_pkg::OP_NONE;
        case (r_state)
            mcfbs_pkg::S_IDLE:        o_cmd.in_ready = 1'b1;
            mcfbs_pkg::S_DIV_STAMP:   o_cmd.op = mcfbs_pkg::OP_DIV_STAMP;
            mcfbs_pkg::S_PLACE:       o_cmd.op = mcfbs_pkg::OP_PLACE;
            mcfbs_pkg::S_FIND_FIRST:  o_cmd.op = mcfbs_pkg::OP_FIND_FIRST;
            mcfbs_pkg::S_SET_A:       o_cmd.op = mcfbs_pkg::OP_SET_A;
            mcfbs_pkg::S_CHECK:
                if (i_status.all_a) o_cmd.op = mcfbs_pkg::OP_PICK_A;
            mcfbs_pkg::S_FIND_NEXT:   o_cmd.op = mcfbs_pkg::OP_FIND_NEXT;
            mcfbs_pkg::S_TRY_B:       o_cmd.op = mcfbs_pkg::OP_TRYB;
            mcfbs_pkg::S_MADDR:       o_cmd.op = mcfbs_pkg::OP_MADDR;
            mcfbs_pkg::S_MCMP:        o_cmd.op = mcfbs_pkg::OP_MCMP;
            mcfbs_pkg::S_JUDGE:       o_cmd.op = mcfbs_pkg::OP_JUDGE;
            mcfbs_pkg::S_DIV_MASTER:  o_cmd.op = mcfbs_pkg::OP_DIV_MASTER;
            mcfbs_pkg::S_TREAD:       o_cmd.op = mcfbs_pkg::OP_TREAD;
            mcfbs_pkg::S_EMIT:
                if (i_status.out_free) o_cmd.op = mcfbs_pkg::OP_EMIT;
            mcfbs_pkg::S_FREE:        o_cmd.op = mcfbs_pkg::OP_FREE;
            mcfbs_pkg::S_EVICT_FIND:  o_cmd.op = mcfbs_pkg::OP_FIND_FIRST;
            mcfbs_pkg::S_EVICT_KILL:  o_cmd.op = mcfbs_pkg::OP_KILL;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/multi_camera_frame_bucket_sync.sv =====
// ----------------------------------------------------------------------------
// multi_camera_frame_bucket_sync: approximate-time multi-camera synchronizer
// Sorts rgb, depth and confidence frames into time buckets and publishes one
// entry per camera whenever a complete, newer snapshot can be formed.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  i_in      in         kind, camera, stream, stamp_ns, frame_tag
//  o_out     out        out_camera, rgb/depth/conf tags, snapshot stamp, last
//  i_cfg     in         register index and data (grid_ns, cameras_in_use)
//
//  A calibration item or a gated frame is taken while staying idle. A frame
//  passes the bit-serial divider, one slot sweep of MAX_BUCKETS+1 slots
//  per bucket visited in the ordered scan, and a master-stamp step per
//  camera; a published snapshot adds a second divider pass, tag reads per
//  camera and one more sweep to free buckets. Eviction adds one sweep.
//  Reset is synchronous and clears the control state, but not the memories.
//  A stalled output holds the next entry; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module multi_camera_frame_bucket_sync #(
    parameter int NUM_CAMERAS = 3,
    parameter int MAX_BUCKETS = 8,
    parameter int TAG_WIDTH   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mcfbs_in_if.sink     i_in,
    mcfbs_out_if.source  o_out,
    mcfbs_cfg_if.sink    i_cfg
);
    mcfbs_pkg::t_cmd    w_cmd;
    mcfbs_pkg::t_status w_status;

    mcfbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mcfbs_dp #(
        .NUM_CAMERAS (NUM_CAMERAS),
        .MAX_BUCKETS (MAX_BUCKETS),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );
endmodule

// ===== test/tb_multi_camera_frame_bucket_sync.sv =====
// ----------------------------------------------------------------------------
// tb_multi_camera_frame_bucket_sync: self-checking bench for the frame syncer
// Drives calibration and frame items, mirrors the bucket store in a small
// scoreboard class, and checks every published snapshot entry field by field
// under random sender gaps, receiver stalls and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_camera_frame_bucket_sync;

    localparam int STAMP_W    = mcfbs_pkg::STAMP_W;
    localparam int CAM_W      = mcfbs_pkg::CAM_W;
    localparam int STREAM_W   = mcfbs_pkg::STREAM_W;
    localparam int STREAMS    = mcfbs_pkg::STREAMS;
    localparam int GRID_W     = mcfbs_pkg::GRID_W;
    localparam int CAMS_W     = mcfbs_pkg::CAMS_W;
    localparam int CFG_IDX_W  = mcfbs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mcfbs_pkg::CFG_DATA_W;

    localparam int NCAM   = 3;
    localparam int SLOTS  = 9;
    localparam int TAG_W  = 16;
    localparam int GAP_AFTER_IDLE = 2000;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CALIB = 1'b1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef struct packed {
        logic [CAM_W-1:0]   cam;
        logic [TAG_W-1:0]   rgb;
        logic [TAG_W-1:0]   depth;
        logic [TAG_W-1:0]   conf;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } t_snap_entry;

    // Scoreboard: keeps its own copy of the bucket store and predicts entries.
    class t_snapshot_scoreboard;
        bit                 slot_used [SLOTS];
        logic [63:0]        slot_bucket [SLOTS];
        bit                 present [SLOTS][NCAM][STREAMS];
        logic [TAG_W-1:0]   tag_mem [SLOTS][NCAM][STREAMS];
        logic [STAMP_W-1:0] rgb_stamp [SLOTS][NCAM];
        logic [STAMP_W-1:0] newest;
        bit                 published;
        bit [NCAM-1:0]      calib;
        logic [GRID_W-1:0]  grid;
        logic [CAMS_W-1:0]  cams;
        t_snap_entry        expected [$];
        int                 errors;
        int                 entries_checked;
        int                 snapshots;

        function new();
            grid = mcfbs_pkg::GRID_RESET;
            cams = mcfbs_pkg::CAMS_RESET;
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
            newest = '0;
            published = 0;
            calib = '0;
            errors = 0;
            entries_checked = 0;
            snapshots = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == mcfbs_pkg::REG_GRID) grid = data[GRID_W-1:0];
            else if (idx == mcfbs_pkg::REG_CAMS) cams = data[CAMS_W-1:0];
        endfunction

        function int active_cams();
            if (cams == 0) return 1;
            if (cams > NCAM) return NCAM;
            return cams;
        endfunction

        function logic [63:0] bucket_of(logic [STAMP_W-1:0] s);
            logic [63:0] g;
            logic [63:0] r;
            g = (grid == 0) ? 64'd1 : {34'd0, grid};
            r = {1'b0, s} % g;
            return ({1'b0, s} / g) + ((2 * r >= g) ? 64'd1 : 64'd0);
        endfunction

        function bit cam_ready(int slot, int c);
            return present[slot][c][0] && present[slot][c][1] && present[slot][c][2];
        endfunction

        function void report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endfunction

        // Apply one accepted input item and queue the entries it publishes.
        function void note_item(logic kind, logic [CAM_W-1:0] cam, logic [STREAM_W-1:0] strm,
                                logic [STAMP_W-1:0] stamp, logic [TAG_W-1:0] tag);
            int n, slot, cnt, i, j, c, a, b, st;
            int pick [NCAM];
            int ord [SLOTS];
            logic [63:0] bid, mb;
            logic [STAMP_W-1:0] master;
            bit found, all_a, ok;
            t_snap_entry e;
            if (kind == KIND_CALIB) begin
                if (cam < NCAM) calib[cam] = 1;
                return;
            end
            n = active_cams();
            if (cam >= n) return;
            for (c = 0; c < n; c++) if (!calib[c]) return;
            st = (strm == mcfbs_pkg::STREAM_EXTRA) ? int'(mcfbs_pkg::STREAM_CONF) : int'(strm);

            // Find the bucket or open a new one.
            bid = bucket_of(stamp);
            slot = -1;
            for (i = 0; i < SLOTS; i++)
                if (slot < 0 && slot_used[i] && slot_bucket[i] == bid) slot = i;
            if (slot < 0) begin
                for (i = 0; i < SLOTS; i++) if (slot < 0 && !slot_used[i]) slot = i;
                if (slot < 0) return;
                slot_used[slot] = 1;
                slot_bucket[slot] = bid;
                for (c = 0; c < NCAM; c++)
                    for (j = 0; j < STREAMS; j++) present[slot][c][j] = 0;
            end
            present[slot][cam][st] = 1;
            tag_mem[slot][cam][st] = tag;
            if (st == 0) rgb_stamp[slot][cam] = stamp;

            // Live buckets, oldest first.
            cnt = 0;
            for (i = 0; i < SLOTS; i++) begin
                if (slot_used[i]) begin
                    j = cnt;
                    while (j > 0 && slot_bucket[ord[j-1]] > slot_bucket[i]) begin
                        ord[j] = ord[j-1];
                        j--;
                    end
                    ord[j] = i;
                    cnt++;
                end
            end

            // First complete bucket, or one filled from its newer neighbor.
            found = 0;
            for (i = 0; i < cnt && !found; i++) begin
                a = ord[i];
                all_a = 1;
                for (c = 0; c < n; c++) if (!cam_ready(a, c)) all_a = 0;
                if (all_a) begin
                    for (c = 0; c < n; c++) pick[c] = a;
                    found = 1;
                end else if (i + 1 < cnt) begin
                    b = ord[i+1];
                    ok = 1;
                    for (c = 0; c < n && ok; c++) begin
                        if (cam_ready(a, c)) pick[c] = a;
                        else if (cam_ready(b, c)) pick[c] = b;
                        else ok = 0;
                    end
                    if (ok) found = 1;
                end
            end

            if (found) begin
                master = rgb_stamp[pick[0]][0];
                for (c = 1; c < n; c++)
                    if (rgb_stamp[pick[c]][c] < master) master = rgb_stamp[pick[c]][c];
                if (published && master <= newest) begin
                    found = 0;
                end else begin
                    newest = master;
                    published = 1;
                end
            end

            if (found) begin
                mb = bucket_of(master);
                for (c = 0; c < n; c++) begin
                    e.cam   = c[CAM_W-1:0];
                    e.rgb   = tag_mem[pick[c]][c][0];
                    e.depth = tag_mem[pick[c]][c][1];
                    e.conf  = tag_mem[pick[c]][c][2];
                    e.stamp = master;
                    e.last  = (c + 1 == n);
                    expected.insert(expected.size(), e);
                    for (j = 0; j < STREAMS; j++) present[pick[c]][c][j] = 0;
                end
                snapshots++;
                for (i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_bucket[i] <= mb) slot_used[i] = 0;
            end

            // Drop the oldest bucket when over capacity.
            cnt = 0;
            slot = -1;
            for (i = 0; i < SLOTS; i++) begin
                if (slot_used[i]) begin
                    cnt++;
                    if (slot < 0 || slot_bucket[i] < slot_bucket[slot]) slot = i;
                end
            end
            if (cnt > SLOTS - 1 && slot >= 0) slot_used[slot] = 0;
        endfunction

        // Compare one published entry with the oldest expectation.
        function void check_entry(t_snap_entry got);
            t_snap_entry e;
            entries_checked++;
            if (expected.size() == 0) begin
                report($sformatf("unexpected entry camera %0d stamp %0d", got.cam, got.stamp));
                return;
            end
            e = expected.pop_front();
            if (got.cam != e.cam)
                report($sformatf("camera got %0d want %0d", got.cam, e.cam));
            if (got.rgb != e.rgb)
                report($sformatf("rgb tag got %h want %h", got.rgb, e.rgb));
            if (got.depth != e.depth)
                report($sformatf("depth tag got %h want %h", got.depth, e.depth));
            if (got.conf != e.conf)
                report($sformatf("conf tag got %h want %h", got.conf, e.conf));
            if (got.stamp != e.stamp)
                report($sformatf("stamp got %0d want %0d", got.stamp, e.stamp));
            if (got.last != e.last)
                report($sformatf("last flag got %0d want %0d", got.last, e.last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mcfbs_in_if  #(.TAG_WIDTH(TAG_W)) in_ch ();
    mcfbs_out_if #(.TAG_WIDTH(TAG_W)) out_ch ();
    mcfbs_cfg_if cfg_ch ();

    multi_camera_frame_bucket_sync #(
        .NUM_CAMERAS(NCAM),
        .MAX_BUCKETS(SLOTS - 1),
        .TAG_WIDTH(TAG_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_snapshot_scoreboard board;
    int items_sent;
    int burst_left;
    int cycle_cnt;
    int stall_mode;
    logic [STAMP_W-1:0] max_stamp_sent;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog.
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver stall pattern, chosen at random from four modes.
    always @(posedge i_clk) begin
        if (cycle_cnt % 256 == 0) stall_mode = $urandom_range(0, 3);
        cycle_cnt <= cycle_cnt + 1;
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            2: out_ch.ready <= (cycle_cnt % 16) < 5;
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Entry monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_entry('{out_ch.out_camera, out_ch.rgb_tag, out_ch.depth_tag,
                                out_ch.conf_tag, out_ch.snapshot_stamp_ns, out_ch.last_entry});
    end

    // Send one item, then maybe pause between bursts.
    task automatic send_item(logic kind, logic [CAM_W-1:0] cam, logic [STREAM_W-1:0] strm,
                             logic [STAMP_W-1:0] stamp, logic [TAG_W-1:0] tag);
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.camera    <= cam;
        in_ch.stream    <= strm;
        in_ch.stamp_ns  <= stamp;
        in_ch.frame_tag <= tag;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_item(kind, cam, strm, stamp, tag);
        items_sent++;
        if (kind == KIND_FRAME && stamp > max_stamp_sent) max_stamp_sent = stamp;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? 80 : $urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected entry is out and the block settles.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected.size() != 0) @(posedge i_clk);
        repeat (GAP_AFTER_IDLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One group of frames around a bucket center, with optional defects.
    task automatic send_group(logic [STAMP_W-1:0] center, bit noisy);
        int n, rot, k, s;
        logic [31:0] jit_max;
        logic [STAMP_W-1:0] stamp;
        logic [STREAM_W-1:0] strm;
        n = board.active_cams();
        jit_max = (board.grid == 0) ? 0 : board.grid / 3;
        for (int c = 0; c < n; c++) begin
            rot = $urandom_range(0, 2);
            for (k = 0; k < STREAMS; k++) begin
                s = (k + rot) % STREAMS;
                strm = s[STREAM_W-1:0];
                if (strm == mcfbs_pkg::STREAM_CONF && $urandom_range(0, 5) == 0)
                    strm = mcfbs_pkg::STREAM_EXTRA;
                stamp = center + $urandom_range(0, jit_max);
                if (noisy && $urandom_range(0, 12) == 0) continue;
                send_item(KIND_FRAME, c[CAM_W-1:0], strm, stamp,
                          TAG_W'($urandom_range(0, 16'hFFFF)));
                if (noisy && $urandom_range(0, 10) == 0)
                    send_item(KIND_FRAME, c[CAM_W-1:0], strm, stamp + 1,
                              TAG_W'($urandom_range(0, 16'hFFFF)));
            end
            if (noisy && $urandom_range(0, 14) == 0)
                send_item(KIND_CALIB, CAM_W'($urandom_range(0, 3)),
                          STREAM_W'($urandom_range(0, 3)), STAMP_W'({$urandom, $urandom}),
                          TAG_W'($urandom_range(0, 16'hFFFF)));
            if (noisy && n < 4 && $urandom_range(0, 14) == 0)
                send_item(KIND_FRAME, CAM_W'($urandom_range(n, 3)),
                          STREAM_W'($urandom_range(0, 3)), center,
                          TAG_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // A random phase of mostly well-formed groups, some of them stale.
    task automatic run_phase(int n_items);
        int start;
        logic [63:0] g, now_b, b;
        start = items_sent;
        g = (board.grid == 0) ? 1 : board.grid;
        now_b = max_stamp_sent / g + 2;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 7) == 0 && now_b > 4) begin
                b = now_b - $urandom_range(1, 3);
            end else begin
                now_b = now_b + $urandom_range(1, 2);
                b = now_b;
            end
            send_group(STAMP_W'(b * g), 1'b1);
        end
    endtask

    // Main sequence.
    initial begin
        board = new();
        items_sent = 0;
        burst_left = 4;
        cycle_cnt = 0;
        stall_mode = 0;
        max_stamp_sent = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_FRAME;
        in_ch.camera = '0;
        in_ch.stream = mcfbs_pkg::STREAM_RGB;
        in_ch.stamp_ns = '0;
        in_ch.frame_tag = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mcfbs_pkg::REG_GRID;
        cfg_ch.data = '0;
        out_ch.ready = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: gated frame, calibration edge cases, first snapshot at time zero.
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_RGB, '0, 16'h1234);
        send_item(KIND_CALIB, 2'd3, mcfbs_pkg::STREAM_RGB, '0, '0);
        send_item(KIND_CALIB, 2'd0, mcfbs_pkg::STREAM_RGB, '0, '0);
        send_item(KIND_CALIB, 2'd1, mcfbs_pkg::STREAM_RGB, '0, '0);
        send_item(KIND_CALIB, 2'd1, mcfbs_pkg::STREAM_RGB, '0, '0);
        send_item(KIND_CALIB, 2'd2, mcfbs_pkg::STREAM_RGB, '0, '0);
        send_item(KIND_FRAME, 2'd3, mcfbs_pkg::STREAM_RGB, '0, 16'hAAAA);
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_RGB,   '0, 16'h0000);
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_DEPTH, '0, 16'hFFFF);
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_EXTRA, '0, 16'h5555);
        send_item(KIND_FRAME, 2'd1, mcfbs_pkg::STREAM_RGB,   63'd5, 16'h0001);
        send_item(KIND_FRAME, 2'd1, mcfbs_pkg::STREAM_DEPTH, 63'd6, 16'h0002);
        send_item(KIND_FRAME, 2'd1, mcfbs_pkg::STREAM_CONF,  63'd7, 16'h0003);
        send_item(KIND_FRAME, 2'd2, mcfbs_pkg::STREAM_RGB,   63'd9, 16'h0004);
        send_item(KIND_FRAME, 2'd2, mcfbs_pkg::STREAM_RGB,   63'd8, 16'h0005);
        send_item(KIND_FRAME, 2'd2, mcfbs_pkg::STREAM_DEPTH, 63'd8, 16'h0006);
        send_item(KIND_FRAME, 2'd2, mcfbs_pkg::STREAM_CONF,  63'd8, 16'h0007);
        // Cameras 0 and 1 complete in one bucket, camera 2 completes in the next.
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_RGB,   63'd166650000, 16'h0101);
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_DEPTH, 63'd166650000, 16'h0102);
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_CONF,  63'd166650000, 16'h0103);
        send_item(KIND_FRAME, 2'd1, mcfbs_pkg::STREAM_RGB,   63'd166650010, 16'h0201);
        send_item(KIND_FRAME, 2'd1, mcfbs_pkg::STREAM_DEPTH, 63'd166650010, 16'h0202);
        send_item(KIND_FRAME, 2'd1, mcfbs_pkg::STREAM_CONF,  63'd166650010, 16'h0203);
        send_group(63'd199980000, 1'b0);
        run_phase(40);

        // Hold off until everything is out, without a register change.
        drain();
        run_phase(40);
        drain();

        write_reg(mcfbs_pkg::REG_GRID, 30'd1000);
        write_reg(mcfbs_pkg::REG_CAMS, 30'd1);
        run_phase(60);
        drain();

        write_reg(mcfbs_pkg::REG_GRID, 30'd0);
        write_reg(mcfbs_pkg::REG_CAMS, 30'd2);
        run_phase(60);
        drain();

        write_reg(mcfbs_pkg::REG_GRID, 30'd1000000000);
        write_reg(mcfbs_pkg::REG_CAMS, 30'd3);
        run_phase(60);
        drain();

        write_reg(mcfbs_pkg::REG_GRID, 30'h3FFFFFFF);
        write_reg(mcfbs_pkg::REG_CAMS, 30'h3FFFFFFC);
        run_phase(40);
        drain();

        write_reg(mcfbs_pkg::REG_GRID, 30'd7);
        write_reg(mcfbs_pkg::REG_CAMS, 30'd3);
        run_phase(50);
        drain();

        // Stamps at the top of the range come last, since they end all publishing.
        write_reg(mcfbs_pkg::REG_GRID, 30'd1000);
        send_group(STAMP_MAX - 63'd400, 1'b0);
        send_item(KIND_FRAME, 2'd0, mcfbs_pkg::STREAM_RGB, STAMP_MAX, 16'hFFFF);
        send_group(STAMP_MAX - 63'd400, 1'b0);
        drain();

        $display("run covered %0d items in seven register settings", items_sent);
        $display("%0d snapshots predicted, %0d entries checked, %0d mismatches",
                 board.snapshots, board.entries_checked, board.errors);
        if (board.errors == 0 && board.expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
